/* sv/tfta_pkg.sv */
// Package for the TCP flow table with aging.
// Shared types, codes and constants; no dependencies.
package tfta_pkg;

    localparam int TableDepthDefault = 16;
    localparam logic [7:0] TcpProtocol = 8'd6;
    localparam logic [31:0] TimeoutReset = 32'd1800;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_SCAN   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        RK_HIT     = 3'd0,
        RK_NEW     = 3'd1,
        RK_DROPPED = 3'd2,
        RK_IGNORED = 3'd3,
        RK_EVICTED = 3'd4,
        RK_DONE    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CMD_PACKET  = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_IGNORED = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] len;
        logic [31:0] now;
    } t_item;

endpackage

/* sv/tfta_front.sv */
// Front end: takes command items, classifies them, holds a two-entry queue.
// Depends on tfta_pkg.
module tfta_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  logic [1:0]      i_opcode,
    input  logic [7:0]      i_protocol,
    input  logic [31:0]     i_source_ip,
    input  logic [31:0]     i_dest_ip,
    input  logic [15:0]     i_source_port,
    input  logic [15:0]     i_dest_port,
    input  logic [15:0]     i_payload_length,
    input  logic [31:0]     i_now_seconds,
    output logic            o_q_valid,
    output tfta_pkg::t_item o_q_item,
    input  logic            i_q_pop
);
    tfta_pkg::t_item r_q [2];
    logic            r_rd, r_wr;
    logic [1:0]      r_cnt;
    tfta_pkg::t_item w_item;
    logic            w_push;

    always_comb begin
        w_item.sip   = i_source_ip;
        w_item.dip   = i_dest_ip;
        w_item.sport = i_source_port;
        w_item.dport = i_dest_port;
        w_item.len   = i_payload_length;
        w_item.now   = i_now_seconds;
        unique case (tfta_pkg::t_opcode'(i_opcode))
            tfta_pkg::OP_SCAN:  w_item.cmd = tfta_pkg::CMD_SCAN;
            tfta_pkg::OP_FLUSH: w_item.cmd = tfta_pkg::CMD_FLUSH;
            tfta_pkg::OP_PACKET:
                w_item.cmd = (i_protocol == tfta_pkg::TcpProtocol) ?
                             tfta_pkg::CMD_PACKET : tfta_pkg::CMD_IGNORED;
            default: w_item.cmd = tfta_pkg::CMD_IGNORED;
        endcase
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_item;
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

/* sv/tfta_divider.sv */
// Iterative 32 by 16 unsigned divider, one quotient bit a cycle.
// No dependencies.
module tfta_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic [16:0] w_sh;
    logic [16:0] w_sub;

    assign w_sh   = {r_rem[15:0], r_q[31]};
    assign w_sub  = w_sh - {1'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= 17'd0;
            r_den <= i_den;
        end else if (r_run) begin
            r_q <= {r_q[30:0], !w_sub[16]};
            r_rem <= w_sub[16] ? w_sh : w_sub;
        end
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 6'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= 6'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* sv/tfta_back.sv */
// Back end: flow table, slot walks for match, aging and flush, result output.
// Depends on tfta_pkg and tfta_divider.
module tfta_back #(
    parameter int TABLE_DEPTH = tfta_pkg::TableDepthDefault,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_timeout,
    input  logic            i_q_valid,
    input  tfta_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_strobe,
    output logic [2:0]      o_result_kind,
    output logic [5:0]      o_slot_index,
    output logic [31:0]     o_flow_source_ip,
    output logic [31:0]     o_flow_dest_ip,
    output logic [15:0]     o_flow_source_port,
    output logic [15:0]     o_flow_dest_port,
    output logic [15:0]     o_packet_count,
    output logic [31:0]     o_byte_total,
    output logic [15:0]     o_average_length,
    output logic [31:0]     o_first_seen,
    output logic [31:0]     o_last_seen,
    output logic            o_last
);
    typedef enum logic [2:0] {
        S_IDLE, S_MATCH, S_AGE, S_WALK, S_DIV, S_PLAIN
    } t_state;

    t_state            r_state;
    tfta_pkg::t_item   r_it;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0] r_sip   [TABLE_DEPTH];
    logic [31:0] r_dip   [TABLE_DEPTH];
    logic [15:0] r_sport [TABLE_DEPTH];
    logic [15:0] r_dport [TABLE_DEPTH];
    logic [31:0] r_first [TABLE_DEPTH];
    logic [31:0] r_lastt [TABLE_DEPTH];
    logic [15:0] r_pkts  [TABLE_DEPTH];
    logic [31:0] r_bytes [TABLE_DEPTH];

    logic [IW:0]   r_idx;
    logic [IW-1:0] r_slot;
    logic [2:0]    r_kind;
    logic          r_fin;
    logic          r_div_go;
    logic          w_done;
    logic [31:0]   w_quot;
    logic [IW-1:0] w_i;
    logic          w_hit, w_aged, w_free_any;
    logic [IW-1:0] w_free;
    logic [31:0]   w_room;

    assign w_i = r_idx[IW-1:0];
    assign w_hit = r_valid[w_i] &&
        ((r_sip[w_i] == r_it.sip && r_dip[w_i] == r_it.dip &&
          r_sport[w_i] == r_it.sport && r_dport[w_i] == r_it.dport) ||
         (r_sip[w_i] == r_it.dip && r_dip[w_i] == r_it.sip &&
          r_sport[w_i] == r_it.dport && r_dport[w_i] == r_it.sport));
    assign w_aged = r_it.now >= r_lastt[w_i] &&
                    (r_it.now - r_lastt[w_i]) >= i_timeout;
    assign w_room = 32'hFFFF_FFFF - r_bytes[w_i];

    always_comb begin
        w_free_any = 1'b0;
        w_free = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                w_free_any = 1'b1;
                w_free = IW'(k);
            end
        end
    end

    tfta_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_div_go),
        .i_num  (r_bytes[r_slot]),
        .i_den  (r_pkts[r_slot]),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            o_strobe <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_it  <= i_q_item;
                        r_idx <= '0;
                        unique case (i_q_item.cmd)
                            tfta_pkg::CMD_PACKET: r_state <= S_MATCH;
                            tfta_pkg::CMD_SCAN, tfta_pkg::CMD_FLUSH: r_state <= S_WALK;
                            default: begin
                                r_kind  <= tfta_pkg::RK_IGNORED;
                                r_state <= S_PLAIN;
                            end
                        endcase
                    end
                end
                S_MATCH: begin
                    if (w_hit) begin
                        r_lastt[w_i] <= r_it.now;
                        if (r_pkts[w_i] != 16'hFFFF) r_pkts[w_i] <= r_pkts[w_i] + 16'd1;
                        r_bytes[w_i] <= ({16'd0, r_it.len} > w_room) ? 32'hFFFF_FFFF :
                                        r_bytes[w_i] + {16'd0, r_it.len};
                        r_slot   <= w_i;
                        r_kind   <= tfta_pkg::RK_HIT;
                        r_fin    <= 1'b1;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end else if (r_idx == (IW+1)'(TABLE_DEPTH - 1)) begin
                        if (w_free_any) r_state <= S_AGE;
                        else begin
                            r_idx   <= '0;
                            r_state <= S_WALK;
                        end
                    end else r_idx <= r_idx + (IW+1)'(1);
                end
                S_AGE: begin
                    if (w_free_any) begin
                        r_valid[w_free] <= 1'b1;
                        r_sip[w_free]   <= r_it.sip;
                        r_dip[w_free]   <= r_it.dip;
                        r_sport[w_free] <= r_it.sport;
                        r_dport[w_free] <= r_it.dport;
                        r_first[w_free] <= r_it.now;
                        r_lastt[w_free] <= r_it.now;
                        r_pkts[w_free]  <= 16'd1;
                        r_bytes[w_free] <= {16'd0, r_it.len};
                        r_slot   <= w_free;
                        r_kind   <= tfta_pkg::RK_NEW;
                        r_fin    <= 1'b1;
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end else begin
                        r_kind  <= tfta_pkg::RK_DROPPED;
                        r_state <= S_PLAIN;
                    end
                end
                S_WALK: begin
                    if (r_idx == (IW+1)'(TABLE_DEPTH)) begin
                        if (r_it.cmd == tfta_pkg::CMD_PACKET) r_state <= S_AGE;
                        else begin
                            r_kind  <= tfta_pkg::RK_DONE;
                            r_state <= S_PLAIN;
                        end
                    end else begin
                        r_idx <= r_idx + (IW+1)'(1);
                        if (r_valid[w_i] &&
                            (r_it.cmd == tfta_pkg::CMD_FLUSH || w_aged)) begin
                            r_valid[w_i] <= 1'b0;
                            r_slot   <= w_i;
                            r_kind   <= tfta_pkg::RK_EVICTED;
                            r_fin    <= 1'b0;
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        o_strobe           <= 1'b1;
                        o_result_kind      <= r_kind;
                        o_slot_index       <= 6'(r_slot);
                        o_flow_source_ip   <= r_sip[r_slot];
                        o_flow_dest_ip     <= r_dip[r_slot];
                        o_flow_source_port <= r_sport[r_slot];
                        o_flow_dest_port   <= r_dport[r_slot];
                        o_packet_count     <= r_pkts[r_slot];
                        o_byte_total       <= r_bytes[r_slot];
                        o_average_length   <= (w_quot[31:16] != 16'd0) ? 16'hFFFF
                                                                       : w_quot[15:0];
                        o_first_seen       <= r_first[r_slot];
                        o_last_seen        <= r_lastt[r_slot];
                        o_last             <= r_fin;
                        r_state            <= r_fin ? S_IDLE : S_WALK;
                    end
                end
                S_PLAIN: begin
                    o_strobe           <= 1'b1;
                    o_result_kind      <= r_kind;
                    o_slot_index       <= '0;
                    o_flow_source_ip   <= '0;
                    o_flow_dest_ip     <= '0;
                    o_flow_source_port <= '0;
                    o_flow_dest_port   <= '0;
                    o_packet_count     <= '0;
                    o_byte_total       <= '0;
                    o_average_length   <= '0;
                    o_first_seen       <= '0;
                    o_last_seen        <= '0;
                    o_last             <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* sv/tcp_flow_table_with_aging_unit.sv */
// Top level of the TCP flow table with aging.
// Depends on tfta_pkg, tfta_front, tfta_back.
//
// Items go into a two-deep queue; busy rises only when the queue is full.
// The back end walks the table one slot a cycle, pausing for the divider after each
// eviction: a packet is matched against the slots in turn until a hit, plus a
// further walk when the table is full; each hit, new flow or eviction result waits
// on a serial divider for the average length. Results appear for one cycle on
// o_strobe and cannot be held off.
module tcp_flow_table_with_aging_unit #(
    parameter int TABLE_DEPTH = tfta_pkg::TableDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_source_ip,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_now_seconds,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_result_kind,
    output logic [5:0]  o_slot_index,
    output logic [31:0] o_flow_source_ip,
    output logic [31:0] o_flow_dest_ip,
    output logic [15:0] o_flow_source_port,
    output logic [15:0] o_flow_dest_port,
    output logic [15:0] o_packet_count,
    output logic [31:0] o_byte_total,
    output logic [15:0] o_average_length,
    output logic [31:0] o_first_seen,
    output logic [31:0] o_last_seen,
    output logic        o_last
);
    logic            w_q_valid, w_q_pop;
    tfta_pkg::t_item w_q_item;
    logic [31:0]     r_timeout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_timeout <= tfta_pkg::TimeoutReset;
        else if (i_cfg_valid) r_timeout <= i_cfg_data;
    end

    tfta_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_opcode(i_opcode), .i_protocol(i_protocol),
        .i_source_ip(i_source_ip), .i_dest_ip(i_dest_ip),
        .i_source_port(i_source_port), .i_dest_port(i_dest_port),
        .i_payload_length(i_payload_length), .i_now_seconds(i_now_seconds),
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop)
    );

    tfta_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_timeout(r_timeout),
        .i_q_valid(w_q_valid), .i_q_item(w_q_item), .o_q_pop(w_q_pop),
        .o_strobe(o_strobe), .o_result_kind(o_result_kind),
        .o_slot_index(o_slot_index), .o_flow_source_ip(o_flow_source_ip),
        .o_flow_dest_ip(o_flow_dest_ip), .o_flow_source_port(o_flow_source_port),
        .o_flow_dest_port(o_flow_dest_port), .o_packet_count(o_packet_count),
        .o_byte_total(o_byte_total), .o_average_length(o_average_length),
        .o_first_seen(o_first_seen), .o_last_seen(o_last_seen), .o_last(o_last)
    );
endmodule
